// ----- src/amt_pkg.sv -----
// Shared constants, codes and types of the adaptive mean threshold unit.
package amt_pkg;

    // Frame and window limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_WINDOW = 15;

    // Field and register widths.
    localparam int PIX_W     = 8;
    localparam int WIN_W     = 4;
    localparam int OFS_W     = 9;
    localparam int IMG_W     = 11;
    localparam int HALF_W    = WIN_W - 1;
    localparam int AREA_W    = 2 * WIN_W;
    localparam int OFFA_W    = OFS_W + AREA_W + 1;
    localparam int PROD_W    = PIX_W + AREA_W;
    localparam int CMP_W     = PROD_W + 3;

    // Counter widths.
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WC_W      = COL_W + 1;
    localparam int OUTR_W    = $clog2(MAX_HEIGHT);
    localparam int HC_W      = OUTR_W + 1;
    localparam int ROW_W     = $clog2(MAX_HEIGHT + MAX_WINDOW + 1);
    localparam int TICK_W    = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_WINDOW + 1));

    // Ring of recent rows, deep enough to hold a full window plus the row being written.
    localparam int RING_W      = $clog2(MAX_WINDOW + 1);
    localparam int RING_ROWS   = 1 << RING_W;
    localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;

    // Column sums and running row prefix sums.
    localparam int CSUM_W    = PIX_W + $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = PROD_W;
    localparam int HI_LEN    = MAX_WINDOW / 2;
    localparam int HI_SEL_W  = $clog2(HI_LEN + 1);
    localparam int HI_IDX_W  = $clog2(HI_LEN);
    localparam int LO_LEN    = MAX_WINDOW;
    localparam int LO_IDX_W  = $clog2(LO_LEN);

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 3);

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_WIN_H = 3'd0,
        REG_WIN_W = 3'd1,
        REG_OFFSET = 3'd2,
        REG_IMG_W = 3'd3,
        REG_IMG_H = 3'd4
    } t_reg_idx;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Beat that has read its memories and awaits the sum update.
    typedef struct packed {
        logic                valid;
        logic                emit;
        logic                last;
        logic                first_row;
        logic                row_start;
        logic                old_ok;
        logic                centre_fwd;
        logic                cs_fwd;
        logic                lo_ok;
        logic [HI_SEL_W-1:0] k;
        logic [PIX_W-1:0]    new_px;
        logic [COL_W-1:0]    col;
    } t_s1;

    // Result under evaluation.
    typedef struct packed {
        logic              emit;
        logic              last;
        logic [PIX_W-1:0]  centre;
        logic [SUM_W-1:0]  phi;
        logic [SUM_W-1:0]  plo;
    } t_s2;

    typedef struct packed {
        logic is_white;
        logic last;
    } t_res;

endpackage

// ----- src/amt_if.sv -----
// Valid/ready channel interfaces for pixel beats and result beats.
interface amt_in_if;
    import amt_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink (input valid, input req_type, input pixel, output ready);
endinterface

interface amt_out_if;
    logic valid;
    logic ready;
    logic is_white;
    logic last;

    modport source (output valid, output is_white, output last, input ready);
    modport sink (input valid, input is_white, input last, output ready);
endinterface

// ----- src/amt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/adaptive_mean_threshold_unit.sv -----
// Streaming local-mean binarizer for 8-bit grey raster frames.
//
//  Channel  Kind        Direction  Payload
//  i_pix    valid/ready in         req_type (0 pixel, 1 flush), pixel[7:0]
//  o_res    valid/ready out        is_white, last
//  APB      psel/penable in/out    paddr[4:2] selects one of five registers
//
// The unit takes one beat per cycle while i_pix.ready is high and registers each
// result in stage 1 and stage 2; results trail the input by hh*W + hw beats.
// The rate is set by the read-modify-write of the column sum memory, which
// completes for every beat, with forwarding between neighbor beats.
// Reset is synchronous and active low. It clears counters and pipeline state;
// the row store is never cleared and column sums restart on row 0 of a frame.
// A four-entry result queue decouples the output: i_pix.ready drops only when
// the queue together with the results still in flight already fill it.
module adaptive_mean_threshold_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    amt_in_if.sink                      i_pix,
    amt_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [amt_pkg::APB_AW-1:0]  paddr,
    input  logic [amt_pkg::APB_DW-1:0]  pwdata,
    output logic [amt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import amt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. They hold the raw written bits; clamping to
    // the legal ranges happens where the values are used.
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]        r_win_h;
    logic [WIN_W-1:0]        r_win_w;
    logic signed [OFS_W-1:0] r_offset;
    logic [IMG_W-1:0]        r_img_w;
    logic [IMG_W-1:0]        r_img_h;
    logic                    cfg_wr;
    t_reg_idx                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_h  <= WIN_W'(3);
            r_win_w  <= WIN_W'(3);
            r_offset <= '0;
            r_img_w  <= IMG_W'(MAX_WIDTH);
            r_img_h  <= IMG_W'(MAX_HEIGHT);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIN_H:  r_win_h  <= pwdata[WIN_W-1:0];
                REG_WIN_W:  r_win_w  <= pwdata[WIN_W-1:0];
                REG_OFFSET: r_offset <= $signed(pwdata[OFS_W-1:0]);
                REG_IMG_W:  r_img_w  <= pwdata[IMG_W-1:0];
                REG_IMG_H:  r_img_h  <= pwdata[IMG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIN_H:  prdata = APB_DW'(r_win_h);
            REG_WIN_W:  prdata = APB_DW'(r_win_w);
            REG_OFFSET: prdata = APB_DW'($unsigned(r_offset));
            REG_IMG_W:  prdata = APB_DW'(r_img_w);
            REG_IMG_H:  prdata = APB_DW'(r_img_h);
            default:    prdata = '0;
        endcase
    end

    // Clamped geometry. A window size of zero acts as one, and the image
    // size is limited to one through the maximum frame size.
    logic [WIN_W-1:0]  win_h_c;
    logic [WIN_W-1:0]  win_w_c;
    logic [HALF_W-1:0] half_h;
    logic [HALF_W-1:0] half_w;
    logic [WC_W-1:0]   img_w_c;
    logic [HC_W-1:0]   img_h_c;
    logic [TICK_W-1:0] lag;

    assign win_h_c = (r_win_h == '0) ? WIN_W'(1) : r_win_h;
    assign win_w_c = (r_win_w == '0) ? WIN_W'(1) : r_win_w;
    assign half_h  = win_h_c[WIN_W-1:1];
    assign half_w  = win_w_c[WIN_W-1:1];
    assign img_w_c = (r_img_w == '0) ? WC_W'(1) :
                     (r_img_w > MAX_WIDTH) ? WC_W'(MAX_WIDTH) : WC_W'(r_img_w);
    assign img_h_c = (r_img_h == '0) ? HC_W'(1) :
                     (r_img_h > MAX_HEIGHT) ? HC_W'(MAX_HEIGHT) : HC_W'(r_img_h);
    assign lag     = TICK_W'(half_h) * TICK_W'(img_w_c) + TICK_W'(half_w);

    // The window area and the scaled offset are registered products so that
    // the compare stage sees no chained multiplication.
    logic [AREA_W-1:0]        r_area;
    logic signed [OFFA_W-1:0] r_off_area;

    always_ff @(posedge i_clk) begin
        r_area     <= AREA_W'(win_h_c) * AREA_W'(win_w_c);
        r_off_area <= OFFA_W'(r_offset) * $signed(OFFA_W'(r_area));
    end

    // ------------------------------------------------------------------
    // Stage 0: position counters, address generation and memory reads.
    // The input position runs hh rows and hw columns ahead of the output
    // position; every beat advances the input, and once the lag is covered
    // every beat also produces the result for the output position.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] r_tick,  n_tick;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_out_c, n_out_c;
    logic [OUTR_W-1:0] r_out_r, n_out_r;

    logic              accept;
    logic              emit;
    logic              last;
    logic              col_wrap;
    logic              out_wrap;
    logic              row_live;
    logic [PIX_W-1:0]  new_px;
    logic [WIN_W-1:0]  span;
    logic              old_ok;
    logic [ROW_W-1:0]  old_row;
    logic [WC_W-1:0]   reach;
    logic [HI_SEL_W-1:0] k_sel;
    logic              lo_ok;

    assign accept   = i_pix.valid && i_pix.ready;
    assign emit     = r_tick >= lag;
    assign last     = emit && (HC_W'(r_out_r) == img_h_c - HC_W'(1))
                           && (WC_W'(r_out_c) == img_w_c - WC_W'(1));
    assign col_wrap = (WC_W'(r_in_col) + WC_W'(1)) >= img_w_c;
    assign out_wrap = (WC_W'(r_out_c) + WC_W'(1)) >= img_w_c;
    assign row_live = WC_W'(r_in_row) < WC_W'(img_h_c);
    assign new_px   = (row_live && (i_pix.req_type == REQ_PIXEL)) ? i_pix.pixel : '0;

    // The row leaving the vertical window is 2*hh+1 rows above the input row.
    assign span     = {half_h, 1'b1};
    assign old_ok   = r_in_row >= ROW_W'(span);
    assign old_row  = r_in_row - ROW_W'(span);

    // When the right edge of the window lies past the end of the row, the
    // right-hand prefix is the row total, pushed k beats earlier.
    assign reach    = WC_W'(r_out_c) + WC_W'(half_w);
    assign k_sel    = (reach >= img_w_c) ? HI_SEL_W'(reach - img_w_c + WC_W'(1)) : '0;
    assign lo_ok    = r_out_c > COL_W'(half_w);

    always_comb begin
        n_tick   = r_tick;
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_out_c  = r_out_c;
        n_out_r  = r_out_r;
        if (accept) begin
            if (last) begin
                n_tick   = '0;
                n_in_col = '0;
                n_in_row = '0;
                n_out_c  = '0;
                n_out_r  = '0;
            end else begin
                n_tick = r_tick + TICK_W'(1);
                if (col_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
                if (emit) begin
                    if (out_wrap) begin
                        n_out_c = '0;
                        n_out_r = r_out_r + OUTR_W'(1);
                    end else begin
                        n_out_c = r_out_c + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_in_col <= '0;
            r_in_row <= '0;
            r_out_c  <= '0;
            r_out_r  <= '0;
        end else begin
            r_tick   <= n_tick;
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_out_c  <= n_out_c;
            r_out_r  <= n_out_r;
        end
    end

    // Two copies of the row ring share every write: one serves the pixel
    // leaving the vertical window, the other the centre pixel.
    logic [RING_W+COL_W-1:0] st_waddr;
    logic [RING_W+COL_W-1:0] st_old_addr;
    logic [RING_W+COL_W-1:0] st_ctr_addr;
    logic [PIX_W-1:0]        st_old_data;
    logic [PIX_W-1:0]        st_ctr_data;
    logic                    st_we;

    assign st_we       = accept && row_live;
    assign st_waddr    = {r_in_row[RING_W-1:0], r_in_col};
    assign st_old_addr = {old_row[RING_W-1:0], r_in_col};
    assign st_ctr_addr = {r_out_r[RING_W-1:0], r_out_c};

    amt_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store_old (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (new_px),
        .i_raddr (st_old_addr),
        .o_rdata (st_old_data)
    );

    amt_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store_ctr (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (new_px),
        .i_raddr (st_ctr_addr),
        .o_rdata (st_ctr_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: column sum update and running row prefix sums.
    // ------------------------------------------------------------------
    t_s1               r_s1, n_s1;
    logic [CSUM_W-1:0] cs_rdata;
    logic [CSUM_W-1:0] r_fwd_data;
    logic [CSUM_W-1:0] cs_old;
    logic [CSUM_W-1:0] col_sum;
    logic [SUM_W-1:0]  prefix;
    logic [SUM_W-1:0]  phi;
    logic [SUM_W-1:0]  plo;
    logic [SUM_W-1:0]  r_p_hi [HI_LEN];
    logic [SUM_W-1:0]  r_p_lo [LO_LEN];

    always_comb begin
        n_s1            = '0;
        n_s1.valid      = accept;
        n_s1.emit       = accept && emit;
        n_s1.last       = last;
        n_s1.first_row  = (r_in_row == '0);
        n_s1.row_start  = (r_in_col == '0);
        n_s1.old_ok     = old_ok;
        n_s1.centre_fwd = (lag == '0);
        n_s1.cs_fwd     = r_s1.valid && (r_s1.col == r_in_col);
        n_s1.lo_ok      = lo_ok;
        n_s1.k          = k_sel;
        n_s1.new_px     = new_px;
        n_s1.col        = r_in_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    amt_ram #(.WIDTH(CSUM_W), .DEPTH(MAX_WIDTH)) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata (col_sum),
        .i_raddr (r_in_col),
        .o_rdata (cs_rdata)
    );

    // Row 0 of a frame starts each column afresh, so leftovers of the
    // previous frame never enter a sum. A neighbor beat on the same column
    // has not reached the memory yet and is forwarded.
    assign cs_old  = r_s1.first_row ? '0 : (r_s1.cs_fwd ? r_fwd_data : cs_rdata);
    assign col_sum = cs_old + CSUM_W'(r_s1.new_px)
                     - (r_s1.old_ok ? CSUM_W'(st_old_data) : '0);

    // Prefix sums wrap modulo 2^SUM_W; the difference of two of them is exact
    // because a window total always fits.
    assign prefix = (r_s1.row_start ? '0 : r_p_hi[0]) + SUM_W'(col_sum);
    assign phi    = (r_s1.k == '0) ? prefix : r_p_hi[HI_IDX_W'(r_s1.k - HI_SEL_W'(1))];
    assign plo    = r_s1.lo_ok ? r_p_lo[LO_IDX_W'({half_w, 1'b0})] : '0;

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_fwd_data <= col_sum;
            r_p_hi[0]  <= prefix;
            r_p_lo[0]  <= prefix;
            for (int i = 1; i < HI_LEN; i++) begin
                r_p_hi[i] <= r_p_hi[i-1];
            end
            for (int i = 1; i < LO_LEN; i++) begin
                r_p_lo[i] <= r_p_lo[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window total and the exact integer threshold compare.
    // ------------------------------------------------------------------
    t_s2                r_s2;
    logic [SUM_W-1:0]   window_total;
    logic [PROD_W-1:0]  centre_area;
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    logic               black;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2.emit   <= r_s1.emit;
            r_s2.last   <= r_s1.last;
            r_s2.centre <= r_s1.centre_fwd ? r_s1.new_px : st_ctr_data;
            r_s2.phi    <= phi;
            r_s2.plo    <= plo;
        end
    end

    assign window_total = r_s2.phi - r_s2.plo;
    assign centre_area  = PROD_W'(r_s2.centre) * PROD_W'(r_area);
    assign lhs          = $signed(CMP_W'(centre_area));
    assign rhs          = $signed(CMP_W'(window_total)) - CMP_W'(r_off_area);
    assign black        = lhs > rhs;

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    t_res               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign push = r_s2.emit;
    assign pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= '{is_white: !black, last: r_s2.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign o_res.valid    = (r_count != '0);
    assign o_res.is_white = r_fifo[r_rptr].is_white;
    assign o_res.last     = r_fifo[r_rptr].last;

    // Admit a beat only if every result already in flight still finds room.
    assign i_pix.ready = (r_count + CNT_W'(r_s1.emit) + CNT_W'(r_s2.emit))
                         < CNT_W'(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid && r_s1.cs_fwd |-> $past(r_s1.valid) && ($past(r_s1.col) == r_s1.col))
        else $error("column sum forwarded from an unrelated beat");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last |=> (r_tick == '0) && (r_in_row == '0) && (r_out_r == '0))
        else $error("counters did not restart after the final result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && emit |=> r_s1.emit ##1 r_s2.emit)
        else $error("result lost in the pipeline");
endmodule

// ----- tb/amt_checker.sv -----
// Checker that predicts every result beat of the threshold unit and compares it.
module amt_checker
    import amt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    input  logic              i_pix_ready,
    input  logic              i_pix_req_type,
    input  logic [PIX_W-1:0]  i_pix_pixel,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic              i_res_is_white,
    input  logic              i_res_last,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results_seen,
    output int                o_whites_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 2 * MAX_WINDOW;

    logic [PIX_W-1:0]        line_mem [RING_DEPTH][MAX_WIDTH];
    logic [WIN_W-1:0]        win_h;
    logic [WIN_W-1:0]        win_w;
    logic signed [OFS_W-1:0] offset_val;
    logic [IMG_W-1:0]        img_w;
    logic [IMG_W-1:0]        img_h;
    int unsigned             tick_col;
    int unsigned             tick_row;
    int unsigned             out_pos;
    t_res                    expected_q [$];
    t_res                    predicted;
    t_res                    oldest;
    int                      mismatches;
    int                      checked;
    int                      whites;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the frame position by one beat and returns 1 when the beat releases a result.
    function automatic bit threshold_tick(input logic req, input logic [PIX_W-1:0] px,
                                          output t_res res);
        int unsigned h;
        int unsigned w;
        int unsigned fw;
        int unsigned fh;
        int unsigned hh;
        int unsigned hw;
        int unsigned r;
        int unsigned c;
        longint      lag;
        longint      tick;
        longint      sum;
        longint      area;
        longint      centre;
        longint      rr;
        longint      cc;
        bit          fin;
        bit          emit;

        h    = clamp_to(win_h, 1, MAX_WINDOW);
        w    = clamp_to(win_w, 1, MAX_WINDOW);
        fw   = clamp_to(img_w, 1, MAX_WIDTH);
        fh   = clamp_to(img_h, 1, MAX_HEIGHT);
        hh   = h / 2;
        hw   = w / 2;
        lag  = longint'(hh) * longint'(fw) + longint'(hw);
        res  = '0;
        emit = 1'b0;

        // Flush beats inside the frame store black; beyond the last row nothing is stored.
        if (tick_row < fh) begin
            line_mem[tick_row % RING_DEPTH][tick_col % MAX_WIDTH] =
                (req == REQ_FLUSH) ? '0 : px;
        end
        tick = longint'(tick_row) * longint'(fw) + longint'(tick_col);

        if (tick >= lag) begin
            r    = out_pos / fw;
            c    = out_pos % fw;
            sum  = 0;
            area = longint'(h) * longint'(w);
            for (int i = -int'(hh); i <= int'(hh); i++) begin
                rr = longint'(r) + i;
                if (rr >= 0 && rr < longint'(fh)) begin
                    for (int j = -int'(hw); j <= int'(hw); j++) begin
                        cc = longint'(c) + j;
                        if (cc >= 0 && cc < longint'(fw))
                            sum = sum + longint'(line_mem[rr % RING_DEPTH][cc % MAX_WIDTH]);
                    end
                end
            end
            centre = (r < fh) ? longint'(line_mem[r % RING_DEPTH][c % MAX_WIDTH]) : 0;
            fin = (longint'(out_pos) + 1 >= longint'(fw) * longint'(fh));
            res.is_white = (centre * area > sum - longint'(offset_val) * area) ? 1'b0 : 1'b1;
            res.last = fin;
            emit = 1'b1;
            if (fin) begin
                tick_col = 0;
                tick_row = 0;
                out_pos  = 0;
                return emit;
            end
            out_pos++;
        end

        tick_col++;
        if (tick_col >= fw) begin
            tick_col = 0;
            tick_row++;
        end
        return emit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_h      = 4'd3;
            win_w      = 4'd3;
            offset_val = '0;
            img_w      = IMG_W'(MAX_WIDTH);
            img_h      = IMG_W'(MAX_HEIGHT);
            tick_col   = 0;
            tick_row   = 0;
            out_pos    = 0;
            mismatches = 0;
            checked    = 0;
            whites     = 0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_WIN_H:  win_h      = i_pwdata[WIN_W-1:0];
                    REG_WIN_W:  win_w      = i_pwdata[WIN_W-1:0];
                    REG_OFFSET: offset_val = i_pwdata[OFS_W-1:0];
                    REG_IMG_W:  img_w      = i_pwdata[IMG_W-1:0];
                    REG_IMG_H:  img_h      = i_pwdata[IMG_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                if (threshold_tick(i_pix_req_type, i_pix_pixel, predicted))
                    expected_q.push_back(predicted);
            end
            if (i_res_valid && i_res_ready) begin
                checked++;
                if (expected_q.size() == 0) begin
                    $error("result beat %0d with no prediction waiting: is_white %0b last %0b",
                           checked, i_res_is_white, i_res_last);
                    mismatches++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (i_res_is_white !== oldest.is_white) begin
                        $error("is_white: expected %0b, actual %0b (result beat %0d)",
                               oldest.is_white, i_res_is_white, checked);
                        mismatches++;
                    end
                    if (i_res_last !== oldest.last) begin
                        $error("last: expected %0b, actual %0b (result beat %0d)",
                               oldest.last, i_res_last, checked);
                        mismatches++;
                    end
                    if (oldest.is_white)
                        whites++;
                end
            end
        end
        o_fail_count   <= mismatches;
        o_pending      <= expected_q.size();
        o_results_seen <= checked;
        o_whites_seen  <= whites;
    end

endmodule

// ----- tb/adaptive_mean_threshold_unit_test.sv -----
// Top of the threshold unit testbench: clock, reset, register writes, beat traffic, verdict.
module adaptive_mean_threshold_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import amt_pkg::*;

    // The run is short: a few thousand beats at most, so this timeout is ample.
    localparam int unsigned TIMEOUT_NS    = 2_000_000;
    localparam int          RESET_CYCLES  = 6;
    localparam int          RANDOM_BEATS  = 850;
    // A result passes through stage 1 and stage 2 into the result queue after the beat
    // that completes a window. This many quiet cycles guarantee it has gone idle.
    localparam int          SETTLE_CYCLES = 16;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    amt_in_if  pix ();
    amt_out_if res ();

    int          fail_count;
    int          pending_results;
    int          results_checked;
    int          white_results;

    // Pixel count and output lag of the frame geometry currently programmed.
    int unsigned frame_pixels;
    int unsigned frame_lag;
    int unsigned burst_left;
    int unsigned beats_sent;
    int unsigned random_beats;
    int unsigned frames_run;
    int unsigned settings_run;
    int unsigned pass_no;
    int unsigned frame_reps;
    int unsigned flush_pct;
    int unsigned beat_mark;
    logic [PIX_W-1:0] seed_pixels [12];

    t_rx_mode    rx_mode;
    int unsigned rx_left;
    int unsigned rx_phase;

    adaptive_mean_threshold_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sees every accepted beat on both channels and every register write.
    amt_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (pix.valid),
        .i_pix_ready    (pix.ready),
        .i_pix_req_type (pix.req_type),
        .i_pix_pixel    (pix.pixel),
        .i_res_valid    (res.valid),
        .i_res_ready    (res.ready),
        .i_res_is_white (res.is_white),
        .i_res_last     (res.last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_results_seen (results_checked),
        .o_whites_seen  (white_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the unit hangs or drops a result.
    initial begin
        #TIMEOUT_NS;
        $display("timeout: the result channel never drained");
        $display("adaptive_mean_threshold_unit: mismatch");
        $finish;
    end

    // The result receiver switches between stall patterns at random, so
    // back-pressure hits the unit in every state of its pipeline and result queue.
    initial begin
        res.ready <= 1'b0;
        rx_left  = 0;
        rx_phase = 0;
        rx_mode  = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:  res.ready <= 1'b1;
                RX_LIGHT: res.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: res.ready <= ($urandom_range(0, 3) == 0);
                default:  res.ready <= ((rx_phase % 7) < 3);
            endcase
        end
    end

    function automatic int unsigned clip_to(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Now and then the unused upper data bits carry junk; the registers must ignore it.
    function automatic logic [APB_DW-1:0] with_spare_bits(input logic [APB_DW-1:0] value);
        if ($urandom_range(0, 3) == 0)
            return value | (APB_DW'($urandom) << 16);
        return value;
    endfunction

    function automatic logic [OFS_W-1:0] small_offset();
        return OFS_W'(int'($urandom_range(0, 40)) - 20);
    endfunction

    // Offsets near zero keep both colors in play; the full field range is hit too.
    function automatic logic [OFS_W-1:0] pick_offset();
        if ($urandom_range(0, 1) == 0)
            return small_offset();
        return OFS_W'($urandom);
    endfunction

    function automatic logic [IMG_W-1:0] pick_width();
        if ($urandom_range(0, 9) < 7)
            return IMG_W'($urandom_range(1, 10));
        return IMG_W'($urandom_range(11, 40));
    endfunction

    function automatic logic [PIX_W-1:0] grey_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // One APB write: setup cycle, access cycle, then an idle cycle so that psel is
    // never lowered and raised at the same edge by two writes in a row.
    task automatic cfg_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Programs all five registers and works out how many beats the frame takes:
    // every pixel plus the flush beats that push out the trailing results.
    task automatic apply_config(input logic [WIN_W-1:0] win_h, input logic [WIN_W-1:0] win_w,
                                input logic [OFS_W-1:0] ofs, input logic [IMG_W-1:0] img_w,
                                input logic [IMG_W-1:0] img_h);
        int unsigned fw;
        int unsigned fh;
        fw = clip_to(img_w, 1, MAX_WIDTH);
        fh = clip_to(img_h, 1, MAX_HEIGHT);
        cfg_write(REG_WIN_H, with_spare_bits(APB_DW'(win_h)));
        cfg_write(REG_WIN_W, with_spare_bits(APB_DW'(win_w)));
        cfg_write(REG_OFFSET, with_spare_bits(APB_DW'(ofs)));
        cfg_write(REG_IMG_W, with_spare_bits(APB_DW'(img_w)));
        cfg_write(REG_IMG_H, with_spare_bits(APB_DW'(img_h)));
        frame_pixels = fw * fh;
        frame_lag    = (clip_to(win_h, 1, MAX_WINDOW) / 2) * fw + clip_to(win_w, 1, MAX_WINDOW) / 2;
        settings_run++;
    endtask

    // Sends one pixel beat. The sender works in bursts; when a burst runs out a gap of
    // random length follows, with junk on the payload while valid is low.
    task automatic send_tick(input logic req, input logic [PIX_W-1:0] px);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap != 0) begin
                pix.valid    <= 1'b0;
                pix.req_type <= 1'($urandom_range(0, 1));
                pix.pixel    <= PIX_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        pix.valid    <= 1'b1;
        pix.req_type <= req;
        pix.pixel    <= px;
        do @(posedge i_clk); while (!pix.ready);
        beats_sent++;
    endtask

    // A whole frame with random content. Some frames carry flush beats among the pixels,
    // which the unit must store as black. The trailing flush beats lie beyond the last
    // row, so their type and pixel are random and must be ignored.
    task automatic run_frame(input int unsigned flush_share);
        logic             req;
        logic [PIX_W-1:0] px;
        for (int unsigned k = 0; k < frame_pixels + frame_lag; k++) begin
            if (k < frame_pixels) begin
                req = ($urandom_range(0, 99) < flush_share) ? REQ_FLUSH : REQ_PIXEL;
                px  = grey_level();
            end else begin
                req = 1'($urandom_range(0, 1));
                px  = PIX_W'($urandom);
            end
            send_tick(req, px);
        end
        frames_run++;
    endtask

    // Lowers valid and waits until every predicted result has been taken, then lets the
    // pipeline settle before any register is touched.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        pix.valid    <= 1'b0;
        pix.req_type <= REQ_PIXEL;
        pix.pixel    <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        burst_left   = 0;
        beats_sent   = 0;
        random_beats = 0;
        frames_run   = 0;
        settings_run = 0;
        pass_no      = 0;
        seed_pixels  = '{8'd0, 8'd255, 8'd128, 8'd255,
                         8'd255, 8'd0, 8'd255, 8'd1,
                         8'd254, 8'd127, 8'd0, 8'd255};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A 4x3 frame under a 3x3 window with edge values. The seventh beat is a flush
        // inside the frame carrying a white pixel, which must be stored as black. The
        // trailing flush beats mix both types to show that type is ignored past the end.
        apply_config(4'd3, 4'd3, 9'd0, 11'd4, 11'd3);
        for (int k = 0; k < 12; k++)
            send_tick((k == 6) ? REQ_FLUSH : REQ_PIXEL, seed_pixels[k]);
        for (int unsigned k = 0; k < frame_lag; k++)
            send_tick(1'(k % 2), (k % 2 == 0) ? 8'd255 : 8'd0);
        frames_run++;
        wait_idle();

        // A single-pixel window has no lag. An offset of -255 must make every
        // pixel white, the most positive one every pixel black.
        apply_config(4'd1, 4'd1, 9'h101, 11'd2, 11'd2);
        for (int k = 0; k < 4; k++)
            send_tick(REQ_PIXEL, seed_pixels[k]);
        frames_run++;
        wait_idle();
        apply_config(4'd1, 4'd1, 9'h0FF, 11'd2, 11'd2);
        for (int k = 0; k < 4; k++)
            send_tick(REQ_PIXEL, seed_pixels[k + 4]);
        frames_run++;
        wait_idle();

        // Random frames. A few passes pin the register extremes: the widest window, zero
        // sizes that clamp to one, an offset of -256, full-width and full-height frames,
        // and a window taller than the frame so the results trail far past its end.
        while (random_beats < RANDOM_BEATS) begin
            case (pass_no)
                1: apply_config(4'd15, 4'd15, 9'd255, 11'd16, 11'd16);
                3: apply_config(4'd0, 4'd0, 9'h100, 11'd0, 11'd0);
                5: apply_config(4'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                small_offset(), 11'd1024, 11'd1);
                7: apply_config(4'd15, 4'd15, small_offset(), 11'd0, 11'd2047);
                9: apply_config(4'd15, 4'd1, small_offset(), 11'd15, 11'd1);
                default: apply_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                      pick_offset(), pick_width(),
                                      11'($urandom_range(1, 10)));
            endcase
            // Small frames sometimes run twice back to back to cross the frame boundary
            // without an idle gap.
            frame_reps = (frame_pixels >= MAX_WIDTH) ? 1 : $urandom_range(1, 2);
            flush_pct  = ($urandom_range(0, 2) == 0) ? 5 : 0;
            for (int unsigned f = 0; f < frame_reps; f++) begin
                beat_mark = beats_sent;
                run_frame(flush_pct);
                if (frame_pixels < MAX_WIDTH)
                    random_beats += beats_sent - beat_mark;
            end
            wait_idle();
            pass_no++;
        end

        $display("Sent %0d pixel beats in %0d frames over %0d register settings.",
                 beats_sent, frames_run, settings_run);
        $display("Checked %0d result beats (%0d white) under sender gaps and receiver stalls.",
                 results_checked, white_results);
        if (fail_count == 0) begin
            $display("adaptive_mean_threshold_unit: match");
        end else begin
            $display("adaptive_mean_threshold_unit: mismatch");
        end
        $finish;
    end

endmodule
